### sv/ac_grid_bus_supervisor_macros.svh
// Assertion helpers used by the supervisor core.
// Both macros expect clk_i, and ACGBS_ASSERT also rst_ni, to be visible at the point of use.
`ifndef AC_GRID_BUS_SUPERVISOR_MACROS_SVH
`define AC_GRID_BUS_SUPERVISOR_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define ACGBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ACGBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/acgbs_pkg.sv
package acgbs_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_FILTER_GAIN  = 3'd0;
  localparam logic [2:0] REG_BUS_REG_LVL  = 3'd1;
  localparam logic [2:0] REG_BUS_PRE_LVL  = 3'd2;
  localparam logic [2:0] REG_GRID_MIN_SQ  = 3'd3;
  localparam logic [2:0] REG_GRID_MAX_SQ  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [15:0] FILTER_GAIN_RST = 16'd66;
  localparam logic [14:0] BUS_REG_LVL_RST = 15'd6080;
  localparam logic [14:0] BUS_PRE_LVL_RST = 15'd4525;
  localparam logic [30:0] GRID_MIN_SQ_RST = 31'd8294400;
  localparam logic [30:0] GRID_MAX_SQ_RST = 31'd17977600;

  // Upper clamp of the mean square, 2^30 LSB squared.
  localparam logic [30:0] MS_MAX = 31'd1073741824;

  // Rounding offset for the Q0.16 gain product.
  localparam logic signed [49:0] ROUND_HALF = 50'sd32768;

  // Converter commands.
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  // Bus voltage bands.
  typedef enum logic [1:0] {
    BAND_LOW  = 2'd0,
    BAND_PEAK = 2'd1,
    BAND_REG  = 2'd2
  } band_e;

  // Operating modes.
  localparam logic [1:0] MODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_CHARGE    = 2'd1;
  localparam logic [1:0] MODE_DISCHARGE = 2'd2;

  // Configuration set seen by the core.
  typedef struct packed {
    logic [15:0] filter_gain;
    logic [14:0] bus_regulation_level;
    logic [14:0] bus_precharge_level;
    logic [30:0] grid_min_square;
    logic [30:0] grid_max_square;
  } cfg_t;

endpackage

### sv/acgbs_if.sv
// Sample request channel.
interface acgbs_sample_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op_mode;
  logic signed [15:0] grid_sample;
  logic signed [15:0] bus_sample;
  logic               pfc_is_idle;
  logic               inverter_is_idle;
  logic               task_tick;

  modport source (
    output valid, op_mode, grid_sample, bus_sample, pfc_is_idle,
           inverter_is_idle, task_tick,
    input  ready
  );
  modport sink (
    input  valid, op_mode, grid_sample, bus_sample, pfc_is_idle,
           inverter_is_idle, task_tick,
    output ready
  );
endinterface

// Result request channel.
interface acgbs_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  bus_band;
  logic        grid_in_window;
  logic [1:0]  pfc_command;
  logic [1:0]  inverter_command;
  logic [30:0] grid_mean_square;

  modport source (
    output valid, bus_band, grid_in_window, pfc_command, inverter_command,
           grid_mean_square,
    input  ready
  );
  modport sink (
    input  valid, bus_band, grid_in_window, pfc_command, inverter_command,
           grid_mean_square,
    output ready
  );
endinterface

### sv/ac_grid_bus_supervisor.sv
// AC grid and DC bus supervisor. Each sample request updates a first-order
// mean-square filter of the grid voltage (gain in Q0.16, clamped to 0..2^30),
// sorts the bus voltage into three bands, checks the mean square against a
// squared grid window and, on task ticks, issues start or stop commands to the
// PFC and the inverter by mode. One result is produced per request. The
// result is registered after the square, difference, scale and update steps,
// which make two passes through one shared 33 x 17 bit multiplier (grid
// square, then gain product) with a subtract and a clamp step around them.
// The block is not ready while a request is in work; a finished result waits
// in its output register while the next request is taken, and the final step
// holds if that register is still full. Configuration writes are taken at any
// cycle and should only be issued while the block is idle.
module ac_grid_bus_supervisor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  acgbs_sample_if.sink   sample_i,
  acgbs_result_if.source result_o
);

  acgbs_pkg::cfg_t cfg_q;

  // Configuration registers; writes beyond the last index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_gain          <= acgbs_pkg::FILTER_GAIN_RST;
      cfg_q.bus_regulation_level <= acgbs_pkg::BUS_REG_LVL_RST;
      cfg_q.bus_precharge_level  <= acgbs_pkg::BUS_PRE_LVL_RST;
      cfg_q.grid_min_square      <= acgbs_pkg::GRID_MIN_SQ_RST;
      cfg_q.grid_max_square      <= acgbs_pkg::GRID_MAX_SQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        acgbs_pkg::REG_FILTER_GAIN: cfg_q.filter_gain          <= cfg_data_i[15:0];
        acgbs_pkg::REG_BUS_REG_LVL: cfg_q.bus_regulation_level <= cfg_data_i[14:0];
        acgbs_pkg::REG_BUS_PRE_LVL: cfg_q.bus_precharge_level  <= cfg_data_i[14:0];
        acgbs_pkg::REG_GRID_MIN_SQ: cfg_q.grid_min_square      <= cfg_data_i;
        acgbs_pkg::REG_GRID_MAX_SQ: cfg_q.grid_max_square      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  acgbs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .sample_i (sample_i),
    .result_o (result_o)
  );

endmodule

### sv/acgbs_mul.sv
// Shared signed multiplier with a registered product.
module acgbs_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [16:0] b_i,
  output logic signed [49:0] p_o
);

  logic signed [49:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 50'(a_i * b_i);
  end

  assign p_o = p_q;

endmodule

### sv/acgbs_core.sv
`include "ac_grid_bus_supervisor_macros.svh"

module acgbs_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  acgbs_pkg::cfg_t      cfg_i,
  acgbs_sample_if.sink         sample_i,
  acgbs_result_if.source       result_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_DIFF,
    S_SCALE,
    S_UPDATE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic [30:0] acc_q;

  // Latched request fields.
  logic [1:0]         mode_q;
  logic signed [15:0] grid_q;
  logic signed [15:0] bus_q;
  logic               pfc_idle_q;
  logic               inv_idle_q;
  logic               tick_q;
  logic signed [32:0] diff_q;

  // Result registers.
  acgbs_pkg::band_e band_q, band_d;
  logic             win_q, win_d;
  acgbs_pkg::cmd_e  pfc_cmd_q, pfc_cmd_d;
  acgbs_pkg::cmd_e  inv_cmd_q, inv_cmd_d;
  logic [30:0]      acc_d;

  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] prod;
  logic signed [49:0] rounded;
  logic signed [33:0] step;
  logic signed [34:0] sum;
  logic               bus_reg;
  logic               bus_pre;
  logic               sample_fire;
  logic               load;

  assign sample_i.ready = (state_q == S_IDLE);
  assign sample_fire    = sample_i.valid && sample_i.ready;
  assign load           = (state_q == S_UPDATE) && (!out_valid_q || result_o.ready);

  // Operand select for the shared multiplier: square first, then gain.
  always_comb begin
    if (state_q == S_SQUARE) begin
      mul_a = 33'(grid_q);
      mul_b = 17'(grid_q);
    end else begin
      mul_a = diff_q;
      mul_b = $signed({1'b0, cfg_i.filter_gain});
    end
  end

  acgbs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Rounded filter step and clamped accumulator.
  always_comb begin
    rounded = prod + acgbs_pkg::ROUND_HALF;
    step    = rounded[49:16];
    sum     = $signed({4'b0, acc_q}) + 35'(step);
    if (sum < 35'sd0) begin
      acc_d = '0;
    end else if (sum > $signed({4'b0, acgbs_pkg::MS_MAX})) begin
      acc_d = acgbs_pkg::MS_MAX;
    end else begin
      acc_d = sum[30:0];
    end
  end

  // Bus band, window check and converter commands.
  always_comb begin
    bus_reg = bus_q >= $signed({1'b0, cfg_i.bus_regulation_level});
    bus_pre = bus_q >= $signed({1'b0, cfg_i.bus_precharge_level});
    if (bus_reg) begin
      band_d = acgbs_pkg::BAND_REG;
    end else if (bus_pre) begin
      band_d = acgbs_pkg::BAND_PEAK;
    end else begin
      band_d = acgbs_pkg::BAND_LOW;
    end
    win_d = (acc_d >= cfg_i.grid_min_square) && (acc_d <= cfg_i.grid_max_square);

    pfc_cmd_d = acgbs_pkg::CMD_NONE;
    inv_cmd_d = acgbs_pkg::CMD_NONE;
    if (tick_q) begin
      case (mode_q)
        acgbs_pkg::MODE_CHARGE: begin
          if (win_d && pfc_idle_q) begin
            pfc_cmd_d = acgbs_pkg::CMD_START;
          end else if (!win_d && !pfc_idle_q) begin
            pfc_cmd_d = acgbs_pkg::CMD_STOP;
          end
          inv_cmd_d = acgbs_pkg::CMD_STOP;
        end
        acgbs_pkg::MODE_DISCHARGE: begin
          pfc_cmd_d = acgbs_pkg::CMD_STOP;
          if (bus_reg && inv_idle_q) begin
            inv_cmd_d = acgbs_pkg::CMD_START;
          end else if (!bus_reg && !inv_idle_q) begin
            inv_cmd_d = acgbs_pkg::CMD_STOP;
          end
        end
        default: begin
          pfc_cmd_d = acgbs_pkg::CMD_STOP;
          inv_cmd_d = acgbs_pkg::CMD_STOP;
        end
      endcase
    end
  end

  // Sequencer, accumulator and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      // A new result takes the output register; otherwise it empties when taken.
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (sample_fire) begin
            state_q <= S_SQUARE;
          end
        end
        S_SQUARE: state_q <= S_DIFF;
        S_DIFF:   state_q <= S_SCALE;
        S_SCALE:  state_q <= S_UPDATE;
        S_UPDATE: begin
          if (load) begin
            acc_q   <= acc_d;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Request latch, difference register and result payload.
  always_ff @(posedge clk_i) begin
    if (sample_fire) begin
      mode_q     <= sample_i.op_mode;
      grid_q     <= sample_i.grid_sample;
      bus_q      <= sample_i.bus_sample;
      pfc_idle_q <= sample_i.pfc_is_idle;
      inv_idle_q <= sample_i.inverter_is_idle;
      tick_q     <= sample_i.task_tick;
    end
    if (state_q == S_DIFF) begin
      diff_q <= $signed({2'b0, prod[30:0]}) - $signed({2'b0, acc_q});
    end
    if (load) begin
      band_q    <= band_d;
      win_q     <= win_d;
      pfc_cmd_q <= pfc_cmd_d;
      inv_cmd_q <= inv_cmd_d;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.bus_band         = band_q;
  assign result_o.grid_in_window   = win_q;
  assign result_o.pfc_command      = pfc_cmd_q;
  assign result_o.inverter_command = inv_cmd_q;
  assign result_o.grid_mean_square = acc_q;

  `ACGBS_ASSERT_ALWAYS(a_acc_clamped, (!rst_ni || acc_q <= acgbs_pkg::MS_MAX), "mean square above clamp")
  `ACGBS_ASSERT(a_busy_after_accept, sample_fire |=> !sample_i.ready, "ready after accept")
  `ACGBS_ASSERT(a_acc_only_on_load, !load |=> $stable(acc_q), "accumulator moved without a result")
  `ACGBS_ASSERT(a_no_cmd_idle, (load && !tick_q) |=> ({pfc_cmd_q, inv_cmd_q} == '0), "command without task tick")
  `ACGBS_ASSERT(a_band_legal, out_valid_q |-> (band_q != 2'd3), "illegal bus band")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import acgbs_pkg::*;

  // Mode 3 has no name in the package; the block treats it as idle.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // An index past the last register; writes to it must be ignored.
  localparam logic [2:0] REG_ABSENT = 3'd7;

  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PHASES    = 5;
  localparam int PHASE_ITEMS      = 90;
  localparam int PRINT_LIMIT      = 100;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] grid;
    logic signed [15:0] bus;
    logic               pfc_idle;
    logic               inv_idle;
    logic               tick;
  } sample_t;

  typedef struct packed {
    band_e       band;
    logic        in_window;
    cmd_e        pfc_cmd;
    cmd_e        inv_cmd;
    logic [30:0] mean_square;
  } result_t;

  // One row of the directed table: a register write or a sample request.
  typedef struct {
    bit          is_write;
    logic [2:0]  reg_index;
    logic [30:0] reg_value;
    sample_t     smp;
    bit          known;
    result_t     want;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [30:0] cfg_data_i;

  acgbs_sample_if sample_if ();
  acgbs_result_if result_if ();

  ac_grid_bus_supervisor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_if),
    .result_o    (result_if)
  );

  // Shadow of the block: configuration and the mean-square accumulator.
  cfg_t        shadow_cfg;
  logic [30:0] shadow_mean_square;
  result_t     pending_results[$];
  step_t       directed_steps[$];

  int error_count = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b0;
  bit hold_request = 1'b0;

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  // Masked register update, mirroring the block's write port.
  function automatic void shadow_write(logic [2:0] idx, logic [30:0] val);
    case (idx)
      REG_FILTER_GAIN: shadow_cfg.filter_gain = val[15:0];
      REG_BUS_REG_LVL: shadow_cfg.bus_regulation_level = val[14:0];
      REG_BUS_PRE_LVL: shadow_cfg.bus_precharge_level = val[14:0];
      REG_GRID_MIN_SQ: shadow_cfg.grid_min_square = val;
      REG_GRID_MAX_SQ: shadow_cfg.grid_max_square = val;
      default: ;
    endcase
  endfunction

  // Filter update, bus band, window check and commands for one sample.
  function automatic result_t supervise_sample(sample_t s);
    longint  square;
    longint  diff;
    longint  next_ms;
    bit      bus_ok;
    result_t r;
    square  = longint'(s.grid) * longint'(s.grid);
    diff    = square - longint'(shadow_mean_square);
    // Round to nearest with halves upward: add half, then floor.
    next_ms = longint'(shadow_mean_square) +
              ((diff * longint'(shadow_cfg.filter_gain) + 32768) >>> 16);
    if (next_ms < 0) begin
      next_ms = 0;
    end else if (next_ms > longint'(MS_MAX)) begin
      next_ms = longint'(MS_MAX);
    end
    shadow_mean_square = next_ms[30:0];

    bus_ok = longint'(s.bus) >= longint'(shadow_cfg.bus_regulation_level);
    if (bus_ok) begin
      r.band = BAND_REG;
    end else if (longint'(s.bus) >= longint'(shadow_cfg.bus_precharge_level)) begin
      r.band = BAND_PEAK;
    end else begin
      r.band = BAND_LOW;
    end
    r.in_window = (shadow_mean_square >= shadow_cfg.grid_min_square) &&
                  (shadow_mean_square <= shadow_cfg.grid_max_square);
    r.mean_square = shadow_mean_square;

    r.pfc_cmd = CMD_NONE;
    r.inv_cmd = CMD_NONE;
    if (s.tick) begin
      case (s.mode)
        MODE_CHARGE: begin
          if (r.in_window && s.pfc_idle) begin
            r.pfc_cmd = CMD_START;
          end else if (!r.in_window && !s.pfc_idle) begin
            r.pfc_cmd = CMD_STOP;
          end
          r.inv_cmd = CMD_STOP;
        end
        MODE_DISCHARGE: begin
          r.pfc_cmd = CMD_STOP;
          if (bus_ok && s.inv_idle) begin
            r.inv_cmd = CMD_START;
          end else if (!bus_ok && !s.inv_idle) begin
            r.inv_cmd = CMD_STOP;
          end
        end
        default: begin
          r.pfc_cmd = CMD_STOP;
          r.inv_cmd = CMD_STOP;
        end
      endcase
    end
    return r;
  endfunction

  function automatic step_t item_row(logic [1:0] mode, int grid, int bus, bit pfc_idle,
                                     bit inv_idle, bit tick, bit known = 1'b0,
                                     result_t want = '0);
    step_t r;
    r.is_write     = 1'b0;
    r.reg_index    = '0;
    r.reg_value    = '0;
    r.smp.mode     = mode;
    r.smp.grid     = 16'(grid);
    r.smp.bus      = 16'(bus);
    r.smp.pfc_idle = pfc_idle;
    r.smp.inv_idle = inv_idle;
    r.smp.tick     = tick;
    r.known        = known;
    r.want         = want;
    return r;
  endfunction

  function automatic step_t write_row(logic [2:0] idx, logic [30:0] val);
    step_t r;
    r = item_row(MODE_IDLE, 0, 0, 1'b0, 1'b0, 1'b0);
    r.is_write  = 1'b1;
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  // Random sample; bus values cluster around the two levels half the time.
  function automatic sample_t random_sample();
    sample_t s;
    int      v;
    s.mode     = 2'($urandom_range(0, 3));
    s.pfc_idle = 1'($urandom_range(0, 1));
    s.inv_idle = 1'($urandom_range(0, 1));
    s.tick     = ($urandom_range(0, 9) < 7);
    if ($urandom_range(0, 1) == 0) begin
      s.grid = 16'($urandom);
    end else begin
      v = int'($urandom_range(0, 4000));
      s.grid = 16'(($urandom_range(0, 1) == 0) ? v : -v);
    end
    case ($urandom_range(0, 3))
      0, 1: s.bus = 16'($urandom);
      2: s.bus = 16'(int'(shadow_cfg.bus_regulation_level) +
                     int'($urandom_range(0, 4)) - 2);
      default: s.bus = 16'(int'(shadow_cfg.bus_precharge_level) +
                           int'($urandom_range(0, 4)) - 2);
    endcase
    return s;
  endfunction

  // Offer one sample request and record its expectation on acceptance.
  task automatic offer_sample(input sample_t s, input bit known, input result_t want);
    result_t predicted;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    sample_if.valid            <= 1'b1;
    sample_if.op_mode          <= s.mode;
    sample_if.grid_sample      <= s.grid;
    sample_if.bus_sample       <= s.bus;
    sample_if.pfc_is_idle      <= s.pfc_idle;
    sample_if.inverter_is_idle <= s.inv_idle;
    sample_if.task_tick        <= s.tick;
    do @(posedge clk_i); while (!sample_if.ready);
    predicted = supervise_sample(s);
    pending_results.push_back(known ? want : predicted);
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic wait_for_results();
    sample_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [30:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_write(idx, val);
    @(posedge clk_i);
  endtask

  // Result side: check each accepted result, then decide the next ready.
  initial begin : result_sink
    int      stall_left;
    int      hold_left;
    result_t got;
    result_t want;
    stall_left = 0;
    hold_left  = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid && result_if.ready) begin
        got.band        = band_e'(result_if.bus_band);
        got.in_window   = result_if.grid_in_window;
        got.pfc_cmd     = cmd_e'(result_if.pfc_command);
        got.inv_cmd     = cmd_e'(result_if.inverter_command);
        got.mean_square = result_if.grid_mean_square;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, mean square", got.mean_square, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.band !== want.band) begin
            report_mismatch("bus_band", got.band, want.band);
          end
          if (got.in_window !== want.in_window) begin
            report_mismatch("grid_in_window", got.in_window, want.in_window);
          end
          if (got.pfc_cmd !== want.pfc_cmd) begin
            report_mismatch("pfc_command", got.pfc_cmd, want.pfc_cmd);
          end
          if (got.inv_cmd !== want.inv_cmd) begin
            report_mismatch("inverter_command", got.inv_cmd, want.inv_cmd);
          end
          if (got.mean_square !== want.mean_square) begin
            report_mismatch("grid_mean_square", got.mean_square, want.mean_square);
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (!rst_ni) begin
        result_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] gain;
    logic [30:0] win_a;
    logic [30:0] win_b;
    logic [14:0] level;

    cfg_we_i                   = 1'b0;
    cfg_index_i                = '0;
    cfg_data_i                 = '0;
    sample_if.valid            = 1'b0;
    sample_if.op_mode          = MODE_IDLE;
    sample_if.grid_sample      = '0;
    sample_if.bus_sample       = '0;
    sample_if.pfc_is_idle      = 1'b0;
    sample_if.inverter_is_idle = 1'b0;
    sample_if.task_tick        = 1'b0;

    shadow_cfg.filter_gain          = FILTER_GAIN_RST;
    shadow_cfg.bus_regulation_level = BUS_REG_LVL_RST;
    shadow_cfg.bus_precharge_level  = BUS_PRE_LVL_RST;
    shadow_cfg.grid_min_square      = GRID_MIN_SQ_RST;
    shadow_cfg.grid_max_square      = GRID_MAX_SQ_RST;
    shadow_mean_square              = '0;

    // Reset settings, zero grid: the mean square stays at zero, out of window.
    directed_steps.push_back(item_row(MODE_IDLE, 0, 0, 1, 1, 1, 1,
      result_t'{BAND_LOW, 1'b0, CMD_STOP, CMD_STOP, 31'd0}));
    directed_steps.push_back(item_row(MODE_DISCHARGE, 0, 32767, 1, 1, 1, 1,
      result_t'{BAND_REG, 1'b0, CMD_STOP, CMD_START, 31'd0}));
    directed_steps.push_back(item_row(MODE_DISCHARGE, 0, -32768, 0, 0, 1, 1,
      result_t'{BAND_LOW, 1'b0, CMD_STOP, CMD_STOP, 31'd0}));
    directed_steps.push_back(item_row(MODE_CHARGE, 0, 6080, 0, 1, 1, 1,
      result_t'{BAND_REG, 1'b0, CMD_STOP, CMD_STOP, 31'd0}));
    directed_steps.push_back(item_row(MODE_CHARGE, 0, 6079, 1, 0, 1, 1,
      result_t'{BAND_PEAK, 1'b0, CMD_NONE, CMD_STOP, 31'd0}));
    directed_steps.push_back(item_row(MODE_DISCHARGE, 0, 4525, 1, 1, 0, 1,
      result_t'{BAND_PEAK, 1'b0, CMD_NONE, CMD_NONE, 31'd0}));
    directed_steps.push_back(item_row(MODE_SPARE, 0, 4524, 0, 0, 1, 1,
      result_t'{BAND_LOW, 1'b0, CMD_STOP, CMD_STOP, 31'd0}));
    directed_steps.push_back(item_row(MODE_DISCHARGE, 0, 6079, 1, 1, 1, 1,
      result_t'{BAND_PEAK, 1'b0, CMD_STOP, CMD_NONE, 31'd0}));
    directed_steps.push_back(item_row(MODE_CHARGE, -32768, 0, 1, 1, 1));
    // Full gain written with upper junk bits; a one-point window.
    directed_steps.push_back(write_row(REG_FILTER_GAIN, 31'h7FFF_FFFF));
    directed_steps.push_back(write_row(REG_GRID_MIN_SQ, 31'd10000));
    directed_steps.push_back(write_row(REG_GRID_MAX_SQ, 31'd10000));
    directed_steps.push_back(item_row(MODE_CHARGE, 100, 0, 1, 0, 1));
    directed_steps.push_back(item_row(MODE_CHARGE, -100, 0, 1, 0, 1));
    directed_steps.push_back(item_row(MODE_CHARGE, 101, 0, 0, 1, 1));
    // Zero gain freezes the filter; a write past the last register is ignored.
    directed_steps.push_back(write_row(REG_FILTER_GAIN, 31'h7FFF_0000));
    directed_steps.push_back(write_row(REG_ABSENT, 31'h1234_5678));
    directed_steps.push_back(item_row(MODE_CHARGE, 32767, 0, 1, 1, 1));
    // Levels at zero, widest window, mean square driven to its ceiling.
    directed_steps.push_back(write_row(REG_FILTER_GAIN, 31'd65535));
    directed_steps.push_back(write_row(REG_BUS_REG_LVL, 31'd0));
    directed_steps.push_back(write_row(REG_BUS_PRE_LVL, 31'd0));
    directed_steps.push_back(write_row(REG_GRID_MIN_SQ, 31'd0));
    directed_steps.push_back(write_row(REG_GRID_MAX_SQ, MS_MAX));
    directed_steps.push_back(item_row(MODE_DISCHARGE, -32768, 0, 1, 1, 1));
    directed_steps.push_back(item_row(MODE_DISCHARGE, -32768, 0, 1, 1, 1));
    directed_steps.push_back(item_row(MODE_DISCHARGE, -32768, 0, 1, 1, 1));
    directed_steps.push_back(item_row(MODE_DISCHARGE, -32768, -1, 0, 0, 1));
    // Levels at their top (masked writes) and an inverted window.
    directed_steps.push_back(write_row(REG_BUS_REG_LVL, 31'h7FFF_FFFF));
    directed_steps.push_back(write_row(REG_BUS_PRE_LVL, 31'h7FFF_7FFF));
    directed_steps.push_back(write_row(REG_GRID_MIN_SQ, GRID_MAX_SQ_RST));
    directed_steps.push_back(write_row(REG_GRID_MAX_SQ, GRID_MIN_SQ_RST));
    directed_steps.push_back(item_row(MODE_DISCHARGE, 32767, 32767, 1, 1, 1));
    directed_steps.push_back(item_row(MODE_CHARGE, 3000, 32766, 0, 1, 1));
    directed_steps.push_back(item_row(MODE_SPARE, -1, -32768, 1, 0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gaps_on = 1'b1;

    // Directed table.
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_write) begin
        wait_for_results();
        write_register(directed_steps[i].reg_index, directed_steps[i].reg_value);
      end else begin
        offer_sample(directed_steps[i].smp, directed_steps[i].known,
                     directed_steps[i].want);
      end
    end

    // Random phases, each under a fresh configuration.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      case ($urandom_range(0, 4))
        0: gain = 16'd0;
        1: gain = 16'hFFFF;
        2: gain = FILTER_GAIN_RST;
        3: gain = 16'($urandom);
        default: gain = 16'($urandom_range(16384, 65535));
      endcase
      write_register(REG_FILTER_GAIN, {15'($urandom), gain});
      level = ($urandom_range(0, 5) == 0) ? 15'h7FFF : 15'($urandom);
      write_register(REG_BUS_REG_LVL, {16'd0, level});
      level = ($urandom_range(0, 5) == 0) ? 15'd0 : 15'($urandom_range(0, int'(level)));
      write_register(REG_BUS_PRE_LVL, {16'd0, level});
      win_a = 31'($urandom_range(0, 1073741824));
      win_b = ($urandom_range(0, 4) == 0) ? MS_MAX : 31'($urandom_range(0, 1073741824));
      // Mostly an ordinary window, sometimes inverted.
      if (($urandom_range(0, 4) == 0) == (win_a <= win_b)) begin
        write_register(REG_GRID_MIN_SQ, win_b);
        write_register(REG_GRID_MAX_SQ, win_a);
      end else begin
        write_register(REG_GRID_MIN_SQ, win_a);
        write_register(REG_GRID_MAX_SQ, win_b);
      end
      gaps_on = (phase != RANDOM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Long receiver hold so the block backs up into its input.
        if (phase == 1 && n == 10) begin
          hold_request = 1'b1;
        end
        // Sender pause until the block has drained.
        if (phase == 2 && n == PHASE_ITEMS / 2) begin
          wait_for_results();
        end
        offer_sample(random_sample(), 1'b0, '0);
      end
    end

    wait_for_results();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
